[hdl/rrfc_pkg.sv]
// Package for the receiver reply frame checker.
// Holds the command and status codes, the frame constants and the types
// shared between the collect and check stages. No dependencies.
`default_nettype none

package rrfc_pkg;

  localparam int unsigned FrameLen = 8;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [7:0] CrChar        = 8'h0D;
  localparam logic [7:0] ChannelReset  = 8'd49;
  localparam logic [7:0] ZeroChar      = 8'h30;
  localparam logic [7:0] NineChar      = 8'h39;
  localparam logic [7:0] ChecksumBias  = 8'h20;
  localparam logic [7:0] EcFormMask    = 8'hC0;
  localparam logic [7:0] EcFormValue   = 8'h40;
  localparam logic [7:0] EcPollMask    = 8'h06;
  localparam logic [7:0] EcOscMask     = 8'h08;
  localparam logic [7:0] EcUnavailMask = 8'h10;
  localparam logic [7:0] EcLevelMask   = 8'h20;
  localparam logic [7:0] HighBitMask   = 8'h80;

  typedef enum logic [1:0] {
    CMD_POLL     = 2'd0,
    CMD_BYTE     = 2'd1,
    CMD_DEADLINE = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_OK          = 4'd0,
    ST_TIMEOUT     = 4'd1,
    ST_COMMS       = 4'd2,
    ST_PROTOCOL    = 4'd3,
    ST_WRONG_CHAN  = 4'd4,
    ST_POLL        = 4'd5,
    ST_OSC_UNLOCK  = 4'd6,
    ST_UNAVAILABLE = 4'd7,
    ST_OVERFLOW    = 4'd8,
    ST_UNDERFLOW   = 4'd9
  } status_t;

  // Frame bytes, byte i of the reply at index i.
  typedef logic [FrameLen-1:0][7:0] frame_t;

  // Finished frame or timeout waiting for the check stage.
  typedef struct packed {
    logic       valid;
    logic       timeout;
    logic [3:0] count;
  } pend_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ZeroChar) && (c <= NineChar);
  endfunction

endpackage

`default_nettype wire

[hdl/rrfc_req_if.sv]
// Input channel of the receiver reply frame checker: command and data byte.
// Depends on nothing.
`default_nettype none

interface rrfc_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

`default_nettype wire

[hdl/rrfc_rsp_if.sv]
// Result channel of the receiver reply frame checker.
// Depends on nothing.
`default_nettype none

interface rrfc_rsp_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [13:0] level_code;
  logic        local_selected;
  logic [7:0]  reported_channel;

  modport source (output valid, output status, output level_code,
                  output local_selected, output reported_channel, input ready);
  modport sink (input valid, input status, input level_code,
                input local_selected, input reported_channel, output ready);
endinterface

`default_nettype wire

[hdl/rrfc_cfg_if.sv]
// Configuration write channel: expected channel code.
// Depends on nothing.
`default_nettype none

interface rrfc_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[hdl/receiver_reply_frame_checker.sv]
// Receiver reply frame checker, top level with the configuration register.
// Depends on rrfc_pkg, the rrfc_*_if interfaces, rrfc_collect and rrfc_check.
`default_nettype none

// Takes one command per cycle on req while req.ready is high: a poll arms the
// checker, received bytes are collected until a carriage return or the eighth
// byte, and a deadline while armed gives a timeout. Each finished frame or
// timeout yields one result on rsp, held first in the collect stage's pending
// slot and then, after the single-pass check, in the output register; both
// hold while rsp is not taken. Bytes and deadlines while not armed give no
// result. The expected channel code resets to ASCII '1' and is written through
// cfg, which is always ready; write it only while no frame is in flight.
module receiver_reply_frame_checker (
  input  wire logic  clk,
  input  wire logic  rst,
  rrfc_req_if.sink   req,
  rrfc_rsp_if.source rsp,
  rrfc_cfg_if.sink   cfg
);

  logic             [7:0] expected_channel;
  logic                   advance;
  rrfc_pkg::pend_t        pend;
  rrfc_pkg::frame_t       frame;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_channel <= rrfc_pkg::ChannelReset;
    end else if (cfg.valid) begin
      expected_channel <= cfg.data;
    end
  end

  rrfc_collect u_collect (
    .clk       (clk),
    .rst       (rst),
    .valid     (req.valid),
    .ready     (req.ready),
    .command   (req.command),
    .data_byte (req.data_byte),
    .advance   (advance),
    .pend      (pend),
    .frame     (frame)
  );

  rrfc_check u_check (
    .clk              (clk),
    .rst              (rst),
    .pend             (pend),
    .frame            (frame),
    .expected_channel (expected_channel),
    .advance          (advance),
    .valid            (rsp.valid),
    .ready            (rsp.ready),
    .status           (rsp.status),
    .level_code       (rsp.level_code),
    .local_selected   (rsp.local_selected),
    .reported_channel (rsp.reported_channel)
  );

endmodule

`default_nettype wire

[hdl/rrfc_collect.sv]
// Collect stage: arm on poll, store reply bytes, detect the end of a frame
// or a timeout. Depends on rrfc_pkg.
`default_nettype none

module rrfc_collect (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid,
  output logic                   ready,
  input  wire logic [1:0]        command,
  input  wire logic [7:0]        data_byte,
  input  wire logic              advance,
  output rrfc_pkg::pend_t        pend,
  output rrfc_pkg::frame_t       frame
);

  logic            armed;
  logic            armed_next;
  logic [3:0]      byte_count;
  logic [3:0]      byte_count_next;
  rrfc_pkg::pend_t pend_next;
  logic            take;
  logic            store_byte;
  logic [3:0]      count_inc;

  // The pending slot frees whenever the check stage moves it on.
  assign ready     = !pend.valid || advance;
  assign take      = valid && ready;
  assign count_inc = byte_count + 4'd1;

  always_comb begin
    armed_next      = armed;
    byte_count_next = byte_count;
    store_byte      = 1'b0;
    pend_next       = pend;
    if (advance) begin
      pend_next.valid = 1'b0;
    end
    if (take) begin
      case (rrfc_pkg::cmd_t'(command))
        rrfc_pkg::CMD_POLL: begin
          armed_next      = 1'b1;
          byte_count_next = 4'd0;
        end
        rrfc_pkg::CMD_DEADLINE: begin
          if (armed) begin
            armed_next        = 1'b0;
            pend_next.valid   = 1'b1;
            pend_next.timeout = 1'b1;
            pend_next.count   = 4'd0;
          end
        end
        rrfc_pkg::CMD_BYTE: begin
          if (armed) begin
            store_byte      = 1'b1;
            byte_count_next = count_inc;
            if (data_byte == rrfc_pkg::CrChar ||
                count_inc >= 4'(rrfc_pkg::FrameLen)) begin
              armed_next        = 1'b0;
              pend_next.valid   = 1'b1;
              pend_next.timeout = 1'b0;
              pend_next.count   = count_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      byte_count <= 4'd0;
      pend       <= '0;
    end else begin
      armed      <= armed_next;
      byte_count <= byte_count_next;
      pend       <= pend_next;
    end
  end

  // Frame bytes are only read once written, so they need no reset.
  always_ff @(posedge clk) begin
    if (store_byte) begin
      frame[byte_count[rrfc_pkg::IdxW-1:0]] <= data_byte;
    end
  end

endmodule

`default_nettype wire

[hdl/rrfc_check.sv]
// Check stage: validates a finished frame combinationally and holds the result
// in the output register. Depends on rrfc_pkg.
`default_nettype none

module rrfc_check (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire rrfc_pkg::pend_t  pend,
  input  wire rrfc_pkg::frame_t frame,
  input  wire logic [7:0]       expected_channel,
  output logic                  advance,
  output logic                  valid,
  input  wire logic             ready,
  output logic [3:0]            status,
  output logic [13:0]           level_code,
  output logic                  local_selected,
  output logic [7:0]            reported_channel
);

  rrfc_pkg::status_t st_calc;
  logic [13:0]       level_calc;
  logic              local_calc;
  logic [7:0]        chan_calc;
  logic              fields_ok;
  logic              early;
  logic              high_bit;
  logic              digits_ok;
  logic [7:0]        sum;
  logic [7:0]        check_char;
  logic [7:0]        ec;

  assign advance = !valid || ready;
  assign ec      = frame[4];

  always_comb begin
    early     = !pend.count[3];
    high_bit  = 1'b0;
    for (int i = 0; i < 7; i++) begin
      high_bit = high_bit | ((frame[i] & rrfc_pkg::HighBitMask) != 8'd0);
    end
    digits_ok = rrfc_pkg::is_digit(frame[0]) && rrfc_pkg::is_digit(frame[1]) &&
                rrfc_pkg::is_digit(frame[2]) && rrfc_pkg::is_digit(frame[3]) &&
                rrfc_pkg::is_digit(frame[5]);
    sum = frame[0] + frame[1] + frame[2] + frame[3] + frame[4] + frame[5];
    check_char = {2'b00, sum[5:0]} + rrfc_pkg::ChecksumBias;
    fields_ok = !early && !high_bit && (frame[7] == rrfc_pkg::CrChar) &&
                digits_ok && (frame[6] == check_char);

    if (early) begin
      st_calc = rrfc_pkg::ST_PROTOCOL;
    end else if (high_bit) begin
      st_calc = rrfc_pkg::ST_COMMS;
    end else if (!fields_ok) begin
      st_calc = rrfc_pkg::ST_PROTOCOL;
    end else if (frame[5] != expected_channel) begin
      st_calc = rrfc_pkg::ST_WRONG_CHAN;
    end else if ((ec & rrfc_pkg::EcFormMask) != rrfc_pkg::EcFormValue) begin
      st_calc = rrfc_pkg::ST_PROTOCOL;
    end else if ((ec & rrfc_pkg::EcPollMask) != 8'd0) begin
      st_calc = rrfc_pkg::ST_POLL;
    end else if ((ec & rrfc_pkg::EcOscMask) != 8'd0) begin
      st_calc = rrfc_pkg::ST_OSC_UNLOCK;
    end else if ((ec & rrfc_pkg::EcUnavailMask) != 8'd0) begin
      st_calc = rrfc_pkg::ST_UNAVAILABLE;
    end else if ((ec & rrfc_pkg::EcLevelMask) != 8'd0) begin
      st_calc = (frame[0] == rrfc_pkg::ZeroChar) ? rrfc_pkg::ST_OVERFLOW
                                                 : rrfc_pkg::ST_UNDERFLOW;
    end else begin
      st_calc = rrfc_pkg::ST_OK;
    end

    // Digits are known to be 0x30..0x39 here, so the low nibble is the value.
    level_calc = 14'd0;
    local_calc = 1'b0;
    if (fields_ok) begin
      level_calc = 14'(frame[0][3:0]) * 14'd1000 + 14'(frame[1][3:0]) * 14'd100 +
                   14'(frame[2][3:0]) * 14'd10 + 14'(frame[3][3:0]);
      local_calc = ec[0];
    end
    chan_calc = (pend.count >= 4'd6) ? frame[5] : 8'd0;

    if (pend.timeout) begin
      st_calc    = rrfc_pkg::ST_TIMEOUT;
      level_calc = 14'd0;
      local_calc = 1'b0;
      chan_calc  = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= pend.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      status           <= st_calc;
      level_code       <= level_calc;
      local_selected   <= local_calc;
      reported_channel <= chan_calc;
    end
  end

  a_pend_count: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !pend.timeout |-> pend.count >= 4'd1 && pend.count <= 4'd8)
    else $error("pending frame with impossible byte count");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    valid && status == rrfc_pkg::ST_TIMEOUT |->
      level_code == 14'd0 && !local_selected && reported_channel == 8'd0)
    else $error("timeout result carries frame fields");

  a_bad_frame_zero: assert property (@(posedge clk) disable iff (rst)
    valid && (status == rrfc_pkg::ST_COMMS || status == rrfc_pkg::ST_PROTOCOL) &&
      level_code != 14'd0 |-> status == rrfc_pkg::ST_PROTOCOL)
    else $error("comms error result carries a level code");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    valid |-> level_code <= 14'd9999)
    else $error("level code beyond four decimal digits");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    $past(valid) && !$past(ready) && !$past(rst) |-> valid && $stable(status))
    else $error("result changed while waiting to be taken");

endmodule

`default_nettype wire
